### src/desks_pkg.sv
`default_nettype none
package desks_pkg;

	localparam int Rounds   = 16;
	localparam int RoundW   = $clog2(Rounds);
	localparam int HalfBits = 28;
	localparam int KeyBytes = 8;
	localparam int GroupW   = 6;
	localparam int Groups   = 8;

	localparam logic [RoundW-1:0] RoundLast = RoundW'(Rounds - 1);

	typedef logic [7:0] pick_map_t [HalfBits];
	typedef logic [4:0] sel_row_t [GroupW];
	typedef sel_row_t   sel_map_t [Groups];

	// PC1: byte index in high nibble, bit (counted after the one-place shift) in low nibble
	localparam pick_map_t PickC = '{
		8'h77, 8'h67, 8'h57, 8'h47, 8'h37, 8'h27, 8'h17, 8'h07,
		8'h76, 8'h66, 8'h56, 8'h46, 8'h36, 8'h26, 8'h16, 8'h06,
		8'h75, 8'h65, 8'h55, 8'h45, 8'h35, 8'h25, 8'h15, 8'h05,
		8'h74, 8'h64, 8'h54, 8'h44
	};

	localparam pick_map_t PickD = '{
		8'h71, 8'h61, 8'h51, 8'h41, 8'h31, 8'h21, 8'h11, 8'h01,
		8'h72, 8'h62, 8'h52, 8'h42, 8'h32, 8'h22, 8'h12, 8'h02,
		8'h73, 8'h63, 8'h53, 8'h43, 8'h33, 8'h23, 8'h13, 8'h03,
		8'h34, 8'h24, 8'h14, 8'h04
	};

	// 1 = double rotation in that round
	localparam logic [Rounds-1:0] RotTwo = 16'b0111_1110_1111_1100;

	// PC2 bit picks, groups 1..4 index C, 5..8 index D
	localparam sel_map_t GroupSel = '{
		'{5'd13, 5'd16, 5'd10, 5'd23, 5'd0,  5'd4 },
		'{5'd2,  5'd27, 5'd14, 5'd5,  5'd20, 5'd9 },
		'{5'd22, 5'd18, 5'd11, 5'd3,  5'd25, 5'd7 },
		'{5'd15, 5'd6,  5'd26, 5'd19, 5'd12, 5'd1 },
		'{5'd12, 5'd23, 5'd2,  5'd8,  5'd18, 5'd26},
		'{5'd1,  5'd11, 5'd22, 5'd16, 5'd4,  5'd19},
		'{5'd15, 5'd20, 5'd10, 5'd27, 5'd5,  5'd24},
		'{5'd17, 5'd13, 5'd21, 5'd7,  5'd0,  5'd3 }
	};

	// key is {byte7, ..., byte0}; pick bit n of a byte means raw bit n-1
	function automatic logic [HalfBits-1:0] pc1_gather(input logic [8*KeyBytes-1:0] key,
			input pick_map_t map);
		logic [HalfBits-1:0] h;
		logic [2:0] bsel;
		logic [2:0] isel;
		h = '0;
		for (int i = 0; i < HalfBits; i++) begin
			bsel = map[i][6:4];
			isel = map[i][2:0];
			if (isel != 3'd0) begin
				h[i] = key[{bsel, 3'(isel - 3'd1)}];
			end
		end
		return h;
	endfunction

	function automatic logic [HalfBits-1:0] rot_half(input logic [HalfBits-1:0] h,
			input logic two);
		return two ? {h[1:0], h[HalfBits-1:2]} : {h[0], h[HalfBits-1:1]};
	endfunction

	function automatic logic [GroupW-1:0] pc2_group(input logic [HalfBits-1:0] h,
			input logic [2:0] s);
		logic [GroupW-1:0] g;
		for (int b = 0; b < GroupW; b++) begin
			g[b] = h[GroupSel[s][b]];
		end
		return g;
	endfunction

endpackage
`default_nettype wire

### src/desks_key_if.sv
`default_nettype none
interface desks_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte_0;
	logic [7:0] key_byte_1;
	logic [7:0] key_byte_2;
	logic [7:0] key_byte_3;
	logic [7:0] key_byte_4;
	logic [7:0] key_byte_5;
	logic [7:0] key_byte_6;
	logic [7:0] key_byte_7;

	modport source (output valid, key_byte_0, key_byte_1, key_byte_2, key_byte_3,
		key_byte_4, key_byte_5, key_byte_6, key_byte_7, input ready);
	modport sink (input valid, key_byte_0, key_byte_1, key_byte_2, key_byte_3,
		key_byte_4, key_byte_5, key_byte_6, key_byte_7, output ready);
endinterface
`default_nettype wire

### src/desks_rkey_if.sv
`default_nettype none
interface desks_rkey_if;
	logic       valid;
	logic       ready;
	logic [3:0] round_index;
	logic       is_last;
	logic [5:0] group_s1;
	logic [5:0] group_s2;
	logic [5:0] group_s3;
	logic [5:0] group_s4;
	logic [5:0] group_s5;
	logic [5:0] group_s6;
	logic [5:0] group_s7;
	logic [5:0] group_s8;

	modport source (output valid, round_index, is_last, group_s1, group_s2, group_s3,
		group_s4, group_s5, group_s6, group_s7, group_s8, input ready);
	modport sink (input valid, round_index, is_last, group_s1, group_s2, group_s3,
		group_s4, group_s5, group_s6, group_s7, group_s8, output ready);
endinterface
`default_nettype wire

### src/des_key_schedule.sv
// Channel   Dir  Beat                                   Handshake
// key       in   one 8-byte key, bit 7 of bytes unused   valid/ready
// rkey      out  one round key: index, last, 8 groups    valid/ready
//
// One key gives sixteen round-key beats, a figure set by the round counter,
// one per cycle when rkey is not stalled.
// The next key is taken in the cycle the sixteenth round is loaded into the
// output register, so keys stream without gaps.
// Reset (arst_n low) clears the busy flag and the output valid; no key in flight.
// A stall on rkey freezes the round counter and both halves; nothing is dropped.
`default_nettype none
module des_key_schedule (
	input  wire          clk,
	input  wire          arst_n,
	desks_key_if.sink    key,
	desks_rkey_if.source rkey
);
	import desks_pkg::*;

	// working halves, as rotated up to the previous round
	logic [HalfBits-1:0] c_q;
	logic [HalfBits-1:0] d_q;
	logic [RoundW-1:0]   round_q;
	logic                busy_q;

	// output register
	logic                out_valid_q;
	logic [RoundW-1:0]   out_round_q;
	logic                out_last_q;
	logic [GroupW-1:0]   out_grp_q [Groups];

	logic                advance;
	logic                key_take;
	logic [HalfBits-1:0] c_rot;
	logic [HalfBits-1:0] d_rot;
	logic [8*KeyBytes-1:0] key_flat;

	// output register free now or emptying this cycle
	assign advance  = busy_q && (!out_valid_q || rkey.ready);
	assign key.ready = !busy_q || (advance && (round_q == RoundLast));
	assign key_take = key.valid && key.ready;

	assign key_flat = {key.key_byte_7, key.key_byte_6, key.key_byte_5, key.key_byte_4,
		key.key_byte_3, key.key_byte_2, key.key_byte_1, key.key_byte_0};

	assign c_rot = rot_half(c_q, RotTwo[round_q]);
	assign d_rot = rot_half(d_q, RotTwo[round_q]);

	// round generator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= '0;
		end else if (key_take) begin
			busy_q  <= 1'b1;
			round_q <= '0;
		end else if (advance) begin
			busy_q  <= (round_q != RoundLast);
			round_q <= round_q + RoundW'(1);
		end
	end

	// halves: PC1 on a new key, else the rotated value once a round is issued
	always_ff @(posedge clk) begin
		if (key_take) begin
			c_q <= pc1_gather(key_flat, PickC);
			d_q <= pc1_gather(key_flat, PickD);
		end else if (advance) begin
			c_q <= c_rot;
			d_q <= d_rot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rkey.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_round_q <= round_q;
			out_last_q  <= (round_q == RoundLast);
			for (int s = 0; s < Groups; s++) begin
				out_grp_q[s] <= pc2_group((s < Groups/2) ? c_rot : d_rot, 3'(s));
			end
		end
	end

	assign rkey.valid       = out_valid_q;
	assign rkey.round_index = out_round_q;
	assign rkey.is_last     = out_last_q;
	assign rkey.group_s1    = out_grp_q[0];
	assign rkey.group_s2    = out_grp_q[1];
	assign rkey.group_s3    = out_grp_q[2];
	assign rkey.group_s4    = out_grp_q[3];
	assign rkey.group_s5    = out_grp_q[4];
	assign rkey.group_s6    = out_grp_q[5];
	assign rkey.group_s7    = out_grp_q[6];
	assign rkey.group_s8    = out_grp_q[7];

`ifndef SYNTHESIS
	// a taken key starts at round 0
	a_key_start: assert property (@(posedge clk) disable iff (!arst_n)
		key_take |=> busy_q && (round_q == '0))
		else $error("key taken but generator not at round 0");

	// keys are refused only while a schedule runs
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!key.ready |-> busy_q)
		else $error("key refused while idle");

	// a non-final round key leaves the generator running
	a_no_early_end: assert property (@(posedge clk) disable iff (!arst_n)
		rkey.valid && rkey.ready && !rkey.is_last |-> busy_q)
		else $error("schedule ended before the last round");

	// round keys come in order within a key
	a_round_order: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (round_q != '0) |-> out_round_q == round_q - RoundW'(1))
		else $error("round key out of order");
`endif

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none
// DES key schedule bench.
//
// Keys go in on the key channel; each accepted key must come back as sixteen
// round-key beats on rkey, in round order.  The bench keeps its own model of
// the schedule (PC1 gather, the per-round rotations of C and D, PC2 group
// picks) and queues sixteen expected beats per accepted key.  A single
// checker process pops the oldest expectation for every rkey beat and
// compares it field by field.
//
// Tests, in order:
//   directed      : zero key, all-ones, top bit only, alternating bits,
//                   one live byte at a time, two printable strings
//   random        : random keys, mixed flavours, random gaps on both sides
//   streaming     : no idling on either side, keys back to back
//   backpressure  : sink holds off for a long stretch while keys keep coming
module testbench;

	import desks_pkg::*;

	localparam int CycleLimit  = 200_000;
	localparam int DrainCycles = 40;
	localparam int HoldCycles  = 300;

	// per-key bytes, [i] is key_byte_i
	typedef logic [7:0][7:0] key_t;

	typedef struct packed {
		logic [3:0]      round_index;
		logic            is_last;
		logic [7:0][5:0] grp;        // [0] is group_s1
	} rkey_t;

	// PC1 picks: byte index in the high nibble, bit in the low nibble where bit n
	// means raw key bit n-1 (the key byte is shifted up one place first)
	localparam logic [7:0] CPick [28] = '{
		8'h77, 8'h67, 8'h57, 8'h47, 8'h37, 8'h27, 8'h17, 8'h07,
		8'h76, 8'h66, 8'h56, 8'h46, 8'h36, 8'h26, 8'h16, 8'h06,
		8'h75, 8'h65, 8'h55, 8'h45, 8'h35, 8'h25, 8'h15, 8'h05,
		8'h74, 8'h64, 8'h54, 8'h44
	};

	localparam logic [7:0] DPick [28] = '{
		8'h71, 8'h61, 8'h51, 8'h41, 8'h31, 8'h21, 8'h11, 8'h01,
		8'h72, 8'h62, 8'h52, 8'h42, 8'h32, 8'h22, 8'h12, 8'h02,
		8'h73, 8'h63, 8'h53, 8'h43, 8'h33, 8'h23, 8'h13, 8'h03,
		8'h34, 8'h24, 8'h14, 8'h04
	};

	// rotation steps per round
	localparam int RoundShift [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

	// PC2: six half-bit positions per S-box group; groups 1..4 from C, 5..8 from D
	localparam int Pc2Pos [8][6] = '{
		'{13, 16, 10, 23,  0,  4},
		'{ 2, 27, 14,  5, 20,  9},
		'{22, 18, 11,  3, 25,  7},
		'{15,  6, 26, 19, 12,  1},
		'{12, 23,  2,  8, 18, 26},
		'{ 1, 11, 22, 16,  4, 19},
		'{15, 20, 10, 27,  5, 24},
		'{17, 13, 21,  7,  0,  3}
	};

	logic clk;
	logic arst_n;

	desks_key_if  key_ch ();
	desks_rkey_if rkey_ch ();

	des_key_schedule i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key_ch),
		.rkey   (rkey_ch)
	);

	rkey_t pending_rkeys [$];   // round keys still owed by the block
	int    error_count  = 0;
	int    cycle_count  = 0;
	bit    src_idle_on  = 1'b1; // random gaps before each key
	bit    sink_idle_on = 1'b1; // random stalls before each round key
	int    hold_len     = 0;    // one-off long stall request for the sink

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// --- prediction ---------------------------------------------------------

	// Build the 28-bit half for one PC1 pick table.
	function automatic logic [27:0] pc1_half(input key_t k, input logic [7:0] picks [28]);
		logic [27:0] h;
		logic [7:0]  shifted;
		int          bsel;
		int          pos;
		h = '0;
		for (int i = 0; i < 28; i++) begin
			bsel    = int'(picks[i][6:4]);
			pos     = int'(picks[i][2:0]);
			shifted = {k[bsel][6:0], 1'b0};   // top bit dropped here
			h[i]    = shifted[pos];
		end
		return h;
	endfunction

	// Queue the sixteen round keys one key should produce.
	task automatic schedule_round_keys(input key_t k);
		logic [27:0] c;
		logic [27:0] d;
		logic [27:0] src;
		rkey_t       rk;
		c = pc1_half(k, CPick);
		d = pc1_half(k, DPick);
		for (int r = 0; r < 16; r++) begin
			// rotate down one place per step, bit 0 wraps to bit 27
			for (int n = 0; n < RoundShift[r]; n++) begin
				c = {c[0], c[27:1]};
				d = {d[0], d[27:1]};
			end
			rk.round_index = 4'(r);
			rk.is_last     = (r == 15);
			for (int s = 0; s < 8; s++) begin
				src = (s < 4) ? c : d;
				for (int b = 0; b < 6; b++)
					rk.grp[s][b] = src[Pc2Pos[s][b] % 28];
			end
			pending_rkeys.push_back(rk);
		end
	endtask

	// --- key side -----------------------------------------------------------

	// Offer one key and hold it until the block takes it.  Valid is left high
	// afterwards; the next call either drops it for a gap or moves straight on.
	task automatic send_key(input key_t k);
		int gap;
		gap = src_idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			key_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		key_ch.valid      <= 1'b1;
		key_ch.key_byte_0 <= k[0];
		key_ch.key_byte_1 <= k[1];
		key_ch.key_byte_2 <= k[2];
		key_ch.key_byte_3 <= k[3];
		key_ch.key_byte_4 <= k[4];
		key_ch.key_byte_5 <= k[5];
		key_ch.key_byte_6 <= k[6];
		key_ch.key_byte_7 <= k[7];
		@(posedge clk);
		while (!key_ch.ready) @(posedge clk);
		schedule_round_keys(k);
	endtask

	function automatic key_t random_key(input int flavour);
		key_t k;
		for (int i = 0; i < 8; i++) begin
			case (flavour)
				0: k[i] = 8'($urandom);                    // anything goes
				1: k[i] = 8'($urandom_range(32, 126));     // printable text
				default: begin                             // text with junk in bit 7
					k[i] = 8'($urandom_range(32, 126));
					k[i][7] = 1'($urandom_range(0, 1));
				end
			endcase
		end
		return k;
	endfunction

	// --- rkey side ----------------------------------------------------------

	task automatic check_round_key(input rkey_t got);
		rkey_t want;
		if (pending_rkeys.size() == 0) begin
			$error("round key beat with nothing expected: round_index %0d", got.round_index);
			error_count++;
		end else begin
			want = pending_rkeys.pop_front();
			if (got.round_index !== want.round_index) begin
				$error("round_index: expected %0d, got %0d", want.round_index, got.round_index);
				error_count++;
			end
			if (got.is_last !== want.is_last) begin
				$error("is_last: expected %0d, got %0d", want.is_last, got.is_last);
				error_count++;
			end
			for (int s = 0; s < 8; s++) begin
				if (got.grp[s] !== want.grp[s]) begin
					$error("group_s%0d: expected 'h%02h, got 'h%02h", s + 1, want.grp[s],
						got.grp[s]);
					error_count++;
				end
			end
		end
	endtask

	// Sink: stalls a random number of cycles before each beat, or for the long
	// stretch when a test asks for one.  Outputs are sampled straight after the
	// edge, so they still hold the values the edge itself saw.
	initial begin : rkey_sink
		int    stall;
		rkey_t got;
		@(posedge arst_n);
		forever begin
			stall = sink_idle_on ? $urandom_range(0, 9) : 0;
			if (hold_len > 0) begin
				stall    = hold_len;
				hold_len = 0;
			end
			if (stall > 0) begin
				rkey_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rkey_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rkey_ch.valid && hold_len == 0) @(posedge clk);
			if (rkey_ch.valid) begin
				got.round_index = rkey_ch.round_index;
				got.is_last     = rkey_ch.is_last;
				got.grp[0]      = rkey_ch.group_s1;
				got.grp[1]      = rkey_ch.group_s2;
				got.grp[2]      = rkey_ch.group_s3;
				got.grp[3]      = rkey_ch.group_s4;
				got.grp[4]      = rkey_ch.group_s5;
				got.grp[5]      = rkey_ch.group_s6;
				got.grp[6]      = rkey_ch.group_s7;
				got.grp[7]      = rkey_ch.group_s8;
				check_round_key(got);
			end
		end
	end

	// --- tests --------------------------------------------------------------

	task automatic test_directed();
		key_t k;
		send_key('0);
		send_key({8{8'hff}});
		send_key({8{8'h7f}});   // same round keys as all-ones: bit 7 is dead
		send_key({8{8'h80}});   // top bit only: must look like the zero key
		send_key({8{8'h55}});
		send_key({8{8'haa}});
		// one live byte at a time shows each byte's route through PC1
		for (int i = 0; i < 8; i++) begin
			k    = '0;
			k[i] = 8'h7f;
			send_key(k);
		end
		send_key("Pa55w0rd");
		send_key("~~~~    ");
	endtask

	task automatic test_random(input int count);
		for (int n = 0; n < count; n++)
			send_key(random_key($urandom_range(0, 2)));
	endtask

	// No idling on either side: keys should stream without gaps.
	task automatic test_streaming(input int count);
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		test_random(count);
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	// Sink goes quiet while keys keep coming, so the block fills and must stall
	// its key input without losing or reordering any round key.
	task automatic test_backpressure(input int count);
		src_idle_on = 1'b0;
		hold_len    = HoldCycles;
		test_random(count);
		src_idle_on = 1'b1;
	endtask

	initial begin
		arst_n             <= 1'b0;
		key_ch.valid       <= 1'b0;
		key_ch.key_byte_0  <= '0;
		key_ch.key_byte_1  <= '0;
		key_ch.key_byte_2  <= '0;
		key_ch.key_byte_3  <= '0;
		key_ch.key_byte_4  <= '0;
		key_ch.key_byte_5  <= '0;
		key_ch.key_byte_6  <= '0;
		key_ch.key_byte_7  <= '0;
		rkey_ch.ready      <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(66);
		test_streaming(10);
		test_backpressure(8);
		test_random(10);
		key_ch.valid <= 1'b0;

		// drain, then give any stray beats time to show up
		while (pending_rkeys.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

### files.f
src/desks_pkg.sv
src/desks_key_if.sv
src/desks_rkey_if.sv
src/des_key_schedule.sv
tb/sv/testbench.sv
